FILE: hw/rtl/wst_pkg.sv
`timescale 1ns / 1ps

package wst_pkg;

  localparam int unsigned SLOTS  = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ADDR_W = 5;
  localparam logic [IDX_W-1:0] NONE = IDX_W'(SLOTS);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_ITER   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_HANDLE = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ITER,
    ST_LINK,
    ST_CLR,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [31:0]      handle;
    logic [31:0]      info_first;
    logic [31:0]      info_second;
    logic [31:0]      context_in;
    logic [IDX_W-1:0] cursor;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [31:0]      handle_out;
    logic [31:0]      info_first_out;
    logic [31:0]      info_second_out;
    logic [31:0]      context_out;
    logic [IDX_W-1:0] next_cursor;
  } out_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] info_first;
    logic [31:0] info_second;
    logic [31:0] context_word;
  } entry_t;

endpackage

FILE: hw/rtl/waiter_slot_table_top.sv
`timescale 1ns / 1ps

// Waiter slot table: a table of up to 32 slots, occupied ones chained by links.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
// transaction: add, remove, find or iterate. Each command gives exactly one
// result transaction on the output channel (out_valid_o / out_stall_i /
// out_data_o). The capacity register is written over the cfg channel
// (cfg_valid_i / cfg_ready_o / cfg_data_i); a write empties the table.
// Iterate and rejected commands do not walk the slots; find and remove
// walk the occupied chain one slot per cycle through the slot memory, up to
// capacity slots; add writes the slot, then its neighbours' links, and scans
// the slots (up to capacity) when the free hint must be rebuilt by the scan.
// One command is in work at a time; the next one is taken once the result
// sits in the output register, even while the receiver stalls.
// Reset: all slots read as empty at once (per-entry valid bits), capacity 32,
// no clearing pass. A stalled result holds in the output register.
module waiter_slot_table_top
  import wst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i
);

  state_e state_q, state_d;
  in_t in_q, in_d;
  out_t res_q, res_d, out_q;
  logic out_valid_q;
  logic [IDX_W-1:0] max_q;
  logic [IDX_W-1:0] first_q, first_d, fh_q, fh_d, fhp_q, fhp_d, fhn_q, fhn_d;
  logic [IDX_W-1:0] cnt_q, cnt_d, s_q, s_d, steps_q, steps_d, a_q, a_d;
  logic phase_q, phase_d, rescan_q, rescan_d;
  logic lp_en_q, lp_en_d, ln_en_q, ln_en_d;
  logic [IDX_W-1:0] lp_addr_q, lp_addr_d, lp_data_q, lp_data_d;
  logic [IDX_W-1:0] ln_addr_q, ln_addr_d, ln_data_q, ln_data_d;

  logic [SLOTS-1:0] vd_q, vp_q, vn_q;
  logic rvd_q, rvp_q, rvn_q;
  entry_t dmem [SLOTS];
  logic [IDX_W-1:0] pmem [SLOTS];
  logic [IDX_W-1:0] nmem [SLOTS];
  entry_t rd_d_q;
  logic [IDX_W-1:0] rd_p_q, rd_n_q;

  logic [ADDR_W-1:0] ra, dw_a, pw_a, nw_a;
  logic dw_en, pw_en, nw_en;
  entry_t dw_d;
  logic [IDX_W-1:0] pw_d, nw_d;

  logic [IDX_W-1:0] cap, cur, pv, nx, c, nstep, rp, rn, a1;
  entry_t rd;
  logic accept, cfg_we, out_load, match;

  assign cap = (max_q > NONE) ? NONE : max_q;
  assign accept = in_valid_i && !in_stall_o;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE) || cfg_valid_i;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign rd = rvd_q ? rd_d_q : '0;
  assign rp = rvp_q ? rd_p_q : '0;
  assign rn = rvn_q ? rd_n_q : '0;
  assign match = (rd.handle == in_q.handle) && (rd.info_first == in_q.info_first) &&
                 (rd.info_second == in_q.info_second);
  assign cur = fh_q;
  assign pv = fhp_q;
  assign nx = fhn_q;
  assign c = (in_data_i.cursor == NONE) ? first_q : in_data_i.cursor;
  assign nstep = steps_q + IDX_W'(1);
  assign a1 = a_q + IDX_W'(1);

  always_comb begin
    state_d = state_q;
    in_d = in_q;
    res_d = res_q;
    first_d = first_q;
    fh_d = fh_q;
    fhp_d = fhp_q;
    fhn_d = fhn_q;
    cnt_d = cnt_q;
    s_d = s_q;
    steps_d = steps_q;
    a_d = a_q;
    phase_d = phase_q;
    rescan_d = rescan_q;
    lp_en_d = lp_en_q;
    lp_addr_d = lp_addr_q;
    lp_data_d = lp_data_q;
    ln_en_d = ln_en_q;
    ln_addr_d = ln_addr_q;
    ln_data_d = ln_data_q;
    ra = '0;
    dw_en = 1'b0;
    dw_a = '0;
    dw_d = '0;
    pw_en = 1'b0;
    pw_a = '0;
    pw_d = '0;
    nw_en = 1'b0;
    nw_a = '0;
    nw_d = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_d = in_data_i;
          res_d = '0;
          res_d.slot_index = NONE;
          res_d.next_cursor = NONE;
          res_d.status = STS_OK;
          state_d = ST_DONE;
          case (in_data_i.cmd)
            CMD_ADD: begin
              if (in_data_i.handle == '0) begin
                res_d.status = STS_BAD_HANDLE;
              end else if (cnt_q >= cap || cur >= cap) begin
                fh_d = NONE;
                fhp_d = NONE;
                fhn_d = NONE;
                res_d.status = STS_FULL;
              end else begin
                dw_en = 1'b1;
                dw_a = cur[ADDR_W-1:0];
                dw_d = {in_data_i.handle, in_data_i.info_first, in_data_i.info_second,
                        in_data_i.context_in};
                pw_en = 1'b1;
                pw_a = cur[ADDR_W-1:0];
                pw_d = pv;
                nw_en = 1'b1;
                nw_a = cur[ADDR_W-1:0];
                nw_d = nx;
                if (pv >= cap) first_d = cur;
                rescan_d = 1'b0;
                if (cur > '0 && (pv >= cap || pv < cur - IDX_W'(1))) begin
                  fh_d = cur - IDX_W'(1);
                  fhn_d = cur;
                end else if (cur + IDX_W'(1) < cap &&
                             (nx >= cap || nx > cur + IDX_W'(1))) begin
                  fh_d = cur + IDX_W'(1);
                  fhp_d = cur;
                end else begin
                  rescan_d = 1'b1;
                end
                lp_en_d = nx < cap;
                lp_addr_d = nx;
                lp_data_d = cur;
                ln_en_d = pv < cap;
                ln_addr_d = pv;
                ln_data_d = cur;
                cnt_d = cnt_q + IDX_W'(1);
                res_d.slot_index = cur;
                state_d = ST_LINK;
              end
            end
            CMD_REMOVE, CMD_FIND: begin
              if (in_data_i.handle == '0) begin
                res_d.status = STS_BAD_HANDLE;
              end else if ((in_data_i.cmd == CMD_REMOVE && cnt_q == '0) ||
                           first_q >= cap) begin
                res_d.status = STS_NOT_FOUND;
              end else begin
                ra = first_q[ADDR_W-1:0];
                s_d = first_q;
                steps_d = '0;
                state_d = ST_WALK;
              end
            end
            CMD_ITER: begin
              if (c < cap) begin
                ra = c[ADDR_W-1:0];
                s_d = c;
                state_d = ST_ITER;
              end else begin
                res_d.status = STS_NOT_FOUND;
              end
            end
            default: begin
              res_d.status = STS_NOT_FOUND;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (match) begin
          res_d.slot_index = s_q;
          if (in_q.cmd == CMD_REMOVE) begin
            cnt_d = cnt_q - IDX_W'(1);
            if (s_q == first_q) first_d = rn;
            lp_en_d = rn < cap;
            lp_addr_d = rn;
            lp_data_d = rp;
            fhn_d = (rn < cap) ? rn : NONE;
            ln_en_d = rp < cap;
            ln_addr_d = rp;
            ln_data_d = rn;
            fhp_d = (rp < cap) ? rp : NONE;
            fh_d = s_q;
            state_d = ST_LINK;
          end else begin
            state_d = ST_DONE;
          end
        end else if (rn < cap && nstep < cap) begin
          ra = rn[ADDR_W-1:0];
          s_d = rn;
          steps_d = nstep;
        end else begin
          res_d.status = STS_NOT_FOUND;
          state_d = ST_DONE;
        end
      end
      ST_ITER: begin
        res_d.slot_index = s_q;
        res_d.handle_out = rd.handle;
        res_d.info_first_out = rd.info_first;
        res_d.info_second_out = rd.info_second;
        res_d.context_out = rd.context_word;
        res_d.next_cursor = rn;
        state_d = ST_DONE;
      end
      ST_LINK: begin
        pw_en = lp_en_q;
        pw_a = lp_addr_q[ADDR_W-1:0];
        pw_d = lp_data_q;
        nw_en = ln_en_q;
        nw_a = ln_addr_q[ADDR_W-1:0];
        nw_d = ln_data_q;
        if (in_q.cmd == CMD_REMOVE) begin
          state_d = ST_CLR;
        end else if (rescan_q) begin
          ra = '0;
          a_d = '0;
          phase_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLR: begin
        dw_en = 1'b1;
        dw_a = s_q[ADDR_W-1:0];
        dw_d = '0;
        pw_en = 1'b1;
        pw_a = s_q[ADDR_W-1:0];
        pw_d = NONE;
        nw_en = 1'b1;
        nw_a = s_q[ADDR_W-1:0];
        nw_d = NONE;
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        ra = a1[ADDR_W-1:0];
        a_d = a1;
        if (!phase_q) begin
          if (rd.handle == '0) begin
            fh_d = a_q;
            fhp_d = (a_q > '0) ? a_q - IDX_W'(1) : NONE;
            phase_d = 1'b1;
            if (a1 >= cap) begin
              fhn_d = NONE;
              state_d = ST_DONE;
            end
          end else if (a1 >= cap) begin
            fh_d = NONE;
            fhp_d = NONE;
            fhn_d = NONE;
            state_d = ST_DONE;
          end
        end else begin
          if (rd.handle != '0) begin
            fhn_d = a_q;
            state_d = ST_DONE;
          end else if (a1 >= cap) begin
            fhn_d = NONE;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      first_d = NONE;
      fh_d = '0;
      fhp_d = NONE;
      fhn_d = NONE;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      max_q <= NONE;
      first_q <= NONE;
      fh_q <= '0;
      fhp_q <= NONE;
      fhn_q <= NONE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      vd_q <= '0;
      vp_q <= '0;
      vn_q <= '0;
      rvd_q <= 1'b0;
      rvp_q <= 1'b0;
      rvn_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      fh_q <= fh_d;
      fhp_q <= fhp_d;
      fhn_q <= fhn_d;
      cnt_q <= cnt_d;
      rvd_q <= vd_q[ra];
      rvp_q <= vp_q[ra];
      rvn_q <= vn_q[ra];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        max_q <= cfg_data_i;
        vd_q <= '0;
        vp_q <= '0;
        vn_q <= '0;
      end else begin
        if (dw_en) vd_q[dw_a] <= 1'b1;
        if (pw_en) vp_q[pw_a] <= 1'b1;
        if (nw_en) vn_q[nw_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    res_q <= res_d;
    s_q <= s_d;
    steps_q <= steps_d;
    a_q <= a_d;
    phase_q <= phase_d;
    rescan_q <= rescan_d;
    lp_en_q <= lp_en_d;
    lp_addr_q <= lp_addr_d;
    lp_data_q <= lp_data_d;
    ln_en_q <= ln_en_d;
    ln_addr_q <= ln_addr_d;
    ln_data_q <= ln_data_d;
    if (out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i) begin
    if (dw_en) dmem[dw_a] <= dw_d;
    if (pw_en) pmem[pw_a] <= pw_d;
    if (nw_en) nmem[nw_a] <= nw_d;
    rd_d_q <= dmem[ra];
    rd_p_q <= pmem[ra];
    rd_n_q <= nmem[ra];
  end

endmodule

FILE: hw/rtl/wst_checker.sv
`timescale 1ns / 1ps

module wst_checker
  import wst_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == STS_OK) == (out_data_o.slot_index < NONE)))
    else $error("status and slot index disagree");

endmodule

bind waiter_slot_table_top wst_checker u_wst_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o(out_data_o)
);
